// ===== hdl/bankers_resource_request_checker_assert.svh =====
// Assertion macros for the banker's request checker.
// Used by the top level; no other dependencies.
`ifndef BANKERS_RESOURCE_REQUEST_CHECKER_ASSERT_SVH
`define BANKERS_RESOURCE_REQUEST_CHECKER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define BRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hdl/brc_pkg.sv =====
// Package for the banker's request checker: sizes, codes and state type.
// No dependencies.
package brc_pkg;
    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 8;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int PROC_IDX_W = 4;
    localparam int RES_IDX_W  = 3;
    localparam int PCOUNT_W   = 5;
    localparam int RCOUNT_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int FIELD_W    = 16;

    typedef enum logic [1:0] {
        ACT_LOAD_PROC  = 2'd0,
        ACT_LOAD_AVAIL = 2'd1,
        ACT_REQUEST    = 2'd2,
        ACT_CHECK      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OVER_NEED   = 2'd1,
        ST_OVER_AVAIL  = 2'd2,
        ST_UNSAFE      = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_NEED,
        S_CHK_AVAIL,
        S_APPLY,
        S_SCAN_INIT,
        S_SCAN_TEST,
        S_SCAN_ADD,
        S_SCAN_END,
        S_ROLLBACK,
        S_RESULT
    } state_t;
endpackage

// ===== hdl/bankers_resource_request_checker.sv =====
// Banker's algorithm request checker, top level with sequencer and one shared compare/add unit.
// Depends on brc_pkg, brc_ram and bankers_resource_request_checker_assert.svh.
//
// A load item is written as it is taken. A request or check item is worked one resource
// element at a time through a single compare and saturating-add unit; every step that reads
// the tables spends one phase on the address and one on the data. The need check reads the
// tables for each element and the available check does not; the grant then updates each
// element. The safety scan first copies available into the work vector, then tests a process
// element by element, adds the allocation of a finished one and passes a process already
// finished. After every process that finishes the walk starts again at process 0, so it
// may test up to P*(P+1)/2 processes (P processes in use). The result waits in an output
// register; the next item is taken once it has gone.
`include "bankers_resource_request_checker_assert.svh"

module bankers_resource_request_checker
#(
    parameter int MAX_PROCESSES = brc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = brc_pkg::MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = brc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input beat.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: action[1:0], process_index[5:2], resource_index[8:6], allocated_count[24:9],
    // needed_count[40:25], amount[56:41], zero fill [63:57]
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // Result beat.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: granted[0], status[2:1], zero fill [7:3]
    output logic [7:0]  m_axis_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [brc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_data
);
    import brc_pkg::*;

    localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int AW    = PW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = COUNT_WIDTH;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    // Unpack the input beat.
    logic [1:0]            in_action;
    logic [PROC_IDX_W-1:0] in_proc;
    logic [RES_IDX_W-1:0]  in_res;
    logic [FIELD_W-1:0]    in_alloc;
    logic [FIELD_W-1:0]    in_need;
    logic [FIELD_W-1:0]    in_amount;
    assign in_action = s_axis_tdata[1:0];
    assign in_proc   = s_axis_tdata[5:2];
    assign in_res    = s_axis_tdata[8:6];
    assign in_alloc  = s_axis_tdata[24:9];
    assign in_need   = s_axis_tdata[40:25];
    assign in_amount = s_axis_tdata[56:41];

    // Configuration registers.
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [RCOUNT_W-1:0] rcount_reg;
    state_t state_reg, state_next;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= PCOUNT_W'(16);
            rcount_reg <= RCOUNT_W'(8);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PROCESS_COUNT)
            begin
                pcount_reg <= cfg_data[PCOUNT_W-1:0];
            end
            else
            begin
                rcount_reg <= cfg_data[RCOUNT_W-1:0];
            end
        end
    end

    // Clamped counts in use, one wider than the index so they can hold the maximum.
    logic [PW:0] np;
    logic [RW:0] nr;
    always_comb
    begin
        if (pcount_reg == '0)
        begin
            np = (PW+1)'(1);
        end
        else if (32'(pcount_reg) > MAX_PROCESSES)
        begin
            np = (PW+1)'(MAX_PROCESSES);
        end
        else
        begin
            np = (PW+1)'(pcount_reg);
        end
        if (rcount_reg == '0)
        begin
            nr = (RW+1)'(1);
        end
        else if (32'(rcount_reg) > MAX_RESOURCES)
        begin
            nr = (RW+1)'(MAX_RESOURCES);
        end
        else
        begin
            nr = (RW+1)'(rcount_reg);
        end
    end

    // Sequencer registers.
    logic [PW:0]   p_reg, p_next;
    logic [RW:0]   r_reg, r_next;
    logic [PW-1:0] req_p_reg, req_p_next;
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic [PW:0]   done_reg, done_next;
    logic          fits_reg, fits_next;
    logic          ok_reg, ok_next;
    logic          out_valid_reg, out_valid_next;
    logic          granted_reg, granted_next;
    logic [1:0]    status_reg, status_next;
    logic [CW-1:0] avail_reg [MAX_RESOURCES];
    logic [CW-1:0] req_reg   [MAX_RESOURCES];
    logic [CW-1:0] work_reg  [MAX_RESOURCES];
    logic [CW-1:0] old_al_reg[MAX_RESOURCES];
    logic [CW-1:0] old_nd_reg[MAX_RESOURCES];
    logic [MAX_RESOURCES-1:0] req_set_reg;

    logic in_beat;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_beat = s_axis_tvalid && s_axis_tready;

    // Table memories (allocation and need), one entry per process and resource.
    logic          al_we, nd_we;
    logic [AW-1:0] al_waddr, nd_waddr, rd_addr;
    logic [CW-1:0] al_wdata, nd_wdata, al_rdata, nd_rdata;

    brc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_alloc_ram
    (
        .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
        .raddr(rd_addr), .rdata(al_rdata)
    );
    brc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_need_ram
    (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(rd_addr), .rdata(nd_rdata)
    );

    // Reads are registered: phase 0 of a step addresses the tables, phase 1 uses the data.
    logic ph_reg, ph_next;
    logic [RW-1:0] ri;
    logic [PW-1:0] pi;
    assign ri = r_reg[RW-1:0];
    assign pi = p_reg[PW-1:0];

    // The shared unit: one compare and one saturating add or a subtract per cycle.
    logic [CW-1:0] cmp_a, cmp_b, add_a, add_b, add_y;
    logic          sub_mode, cmp_gt;
    logic [CW:0]   add_sum;
    assign cmp_gt  = cmp_a > cmp_b;
    assign add_sum = sub_mode ? ({1'b0, add_a} - {1'b0, add_b}) : ({1'b0, add_a} + {1'b0, add_b});
    assign add_y   = (!sub_mode && add_sum[CW]) ? CMAX : add_sum[CW-1:0];

    logic [CW-1:0] req_cur;
    assign req_cur = req_set_reg[ri] ? req_reg[ri] : '0;

    logic last_r;
    assign last_r = (r_reg == nr - (RW+1)'(1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat && in_action == ACT_REQUEST && s_axis_tlast)
                begin
                    if (32'(in_proc) >= MAX_PROCESSES || (PW+1)'(in_proc) >= np)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_CHK_NEED;
                    end
                end
                else if (in_beat && in_action == ACT_CHECK)
                begin
                    state_next = S_SCAN_INIT;
                end
            end
            S_CHK_NEED:
            begin
                if (ph_reg && (cmp_gt || last_r))
                begin
                    state_next = cmp_gt ? S_RESULT : S_CHK_AVAIL;
                end
            end
            S_CHK_AVAIL:
            begin
                if (cmp_gt)
                begin
                    state_next = S_RESULT;
                end
                else if (last_r)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (ph_reg && last_r)
                begin
                    state_next = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT:
            begin
                if (last_r)
                begin
                    state_next = S_SCAN_TEST;
                end
            end
            S_SCAN_TEST:
            begin
                if (p_reg >= np)
                begin
                    state_next = S_SCAN_END;
                end
                else if (ph_reg && last_r && fits_reg && !cmp_gt)
                begin
                    state_next = S_SCAN_ADD;
                end
            end
            S_SCAN_ADD:
            begin
                if (ph_reg && last_r)
                begin
                    state_next = S_SCAN_TEST;
                end
            end
            S_SCAN_END:
            begin
                if (ok_reg && done_reg != np)
                begin
                    state_next = S_ROLLBACK;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_ROLLBACK:
            begin
                if (last_r)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        p_next         = p_reg;
        r_next         = r_reg;
        req_p_next     = req_p_reg;
        fin_next       = fin_reg;
        done_next      = done_reg;
        fits_next      = fits_reg;
        ok_next        = ok_reg;
        ph_next        = 1'b0;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        al_we = 1'b0;
        nd_we = 1'b0;
        al_waddr = '0;
        nd_waddr = '0;
        al_wdata = '0;
        nd_wdata = '0;
        rd_addr  = AW'({req_p_reg, ri});
        cmp_a    = '0;
        cmp_b    = '0;
        add_a    = '0;
        add_b    = '0;
        sub_mode = 1'b0;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                r_next  = '0;
                ok_next = 1'b0;
                if (in_beat && in_action == ACT_LOAD_PROC && 32'(in_proc) < MAX_PROCESSES
                    && 32'(in_res) < MAX_RESOURCES)
                begin
                    al_we    = 1'b1;
                    nd_we    = 1'b1;
                    al_waddr = AW'({PW'(in_proc), RW'(in_res)});
                    nd_waddr = al_waddr;
                    al_wdata = CW'(in_alloc);
                    nd_wdata = CW'(in_need);
                end
                if (in_beat && in_action == ACT_REQUEST)
                begin
                    req_p_next   = PW'(in_proc);
                    granted_next = 1'b0;
                    status_next  = ST_OVER_NEED;
                end
            end
            S_CHK_NEED:
            begin
                ph_next = !ph_reg;
                cmp_a   = req_cur;
                cmp_b   = nd_rdata;
                if (ph_reg)
                begin
                    if (cmp_gt)
                    begin
                        status_next = ST_OVER_NEED;
                    end
                    r_next = last_r ? '0 : r_reg + 1'b1;
                end
            end
            S_CHK_AVAIL:
            begin
                cmp_a  = req_cur;
                cmp_b  = avail_reg[ri];
                r_next = last_r ? '0 : r_reg + 1'b1;
                if (cmp_gt)
                begin
                    status_next = ST_OVER_AVAIL;
                end
            end
            S_APPLY:
            begin
                // Available is updated in its own block; here allocation and need.
                ph_next = !ph_reg;
                ok_next = 1'b1;
                if (ph_reg)
                begin
                    al_we    = 1'b1;
                    nd_we    = 1'b1;
                    al_waddr = AW'({req_p_reg, ri});
                    nd_waddr = al_waddr;
                    add_a    = al_rdata;
                    add_b    = req_cur;
                    al_wdata = add_y;
                    nd_wdata = nd_rdata - req_cur;
                    r_next   = last_r ? '0 : r_reg + 1'b1;
                end
            end
            S_SCAN_INIT:
            begin
                r_next    = last_r ? '0 : r_reg + 1'b1;
                p_next    = '0;
                fin_next  = '0;
                done_next = '0;
                fits_next = 1'b1;
            end
            S_SCAN_TEST:
            begin
                rd_addr = AW'({pi, ri});
                if (p_reg < np)
                begin
                    if (fin_reg[pi])
                    begin
                        p_next = p_reg + 1'b1;
                        r_next = '0;
                    end
                    else
                    begin
                        ph_next = !ph_reg;
                        cmp_a   = nd_rdata;
                        cmp_b   = work_reg[ri];
                        if (ph_reg)
                        begin
                            r_next = last_r ? '0 : r_reg + 1'b1;
                            if (last_r)
                            begin
                                if (fits_reg && !cmp_gt)
                                begin
                                    fin_next[pi] = 1'b1;
                                    done_next    = done_reg + 1'b1;
                                end
                                else
                                begin
                                    p_next = p_reg + 1'b1;
                                end
                                fits_next = 1'b1;
                            end
                            else if (cmp_gt)
                            begin
                                fits_next = 1'b0;
                            end
                        end
                    end
                end
            end
            S_SCAN_ADD:
            begin
                rd_addr = AW'({pi, ri});
                ph_next = !ph_reg;
                add_a   = work_reg[ri];
                add_b   = al_rdata;
                if (ph_reg)
                begin
                    r_next = last_r ? '0 : r_reg + 1'b1;
                    if (last_r)
                    begin
                        p_next = '0;
                    end
                end
            end
            S_SCAN_END:
            begin
                r_next = '0;
                if (done_reg == np)
                begin
                    granted_next = 1'b1;
                    status_next  = ST_OK;
                end
                else
                begin
                    granted_next = 1'b0;
                    status_next  = ST_UNSAFE;
                end
            end
            S_ROLLBACK:
            begin
                al_we    = 1'b1;
                nd_we    = 1'b1;
                al_waddr = AW'({req_p_reg, ri});
                nd_waddr = al_waddr;
                al_wdata = old_al_reg[ri];
                nd_wdata = old_nd_reg[ri];
                r_next   = last_r ? '0 : r_reg + 1'b1;
            end
            S_RESULT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
                r_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ph_reg        <= 1'b0;
            r_reg         <= '0;
            p_reg         <= '0;
            fin_reg       <= '0;
            done_reg      <= '0;
            fits_reg      <= 1'b1;
            ok_reg        <= 1'b0;
            req_set_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ph_reg        <= ph_next;
            r_reg         <= r_next;
            p_reg         <= p_next;
            fin_reg       <= fin_next;
            done_reg      <= done_next;
            fits_reg      <= fits_next;
            ok_reg        <= ok_next;
            if (state_reg == S_RESULT)
            begin
                req_set_reg <= '0;
            end
            else if (in_beat && in_action == ACT_REQUEST && 32'(in_res) < MAX_RESOURCES)
            begin
                req_set_reg[RW'(in_res)] <= 1'b1;
            end
        end
    end

    // Payload registers: vectors, saved entries and the result.
    always_ff @(posedge clk)
    begin
        req_p_reg   <= req_p_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
        if (in_beat && in_action == ACT_LOAD_AVAIL && 32'(in_res) < MAX_RESOURCES)
        begin
            avail_reg[RW'(in_res)] <= CW'(in_amount);
        end
        if (in_beat && in_action == ACT_REQUEST && 32'(in_res) < MAX_RESOURCES)
        begin
            req_reg[RW'(in_res)] <= CW'(in_amount);
        end
        if (state_reg == S_APPLY && ph_reg)
        begin
            old_al_reg[ri] <= al_rdata;
            old_nd_reg[ri] <= nd_rdata;
            avail_reg[ri]  <= avail_reg[ri] - req_cur;
        end
        if (state_reg == S_ROLLBACK)
        begin
            avail_reg[ri] <= avail_reg[ri] + req_cur;
        end
        if (state_reg == S_SCAN_INIT)
        begin
            work_reg[ri] <= avail_reg[ri];
        end
        if (state_reg == S_SCAN_ADD && ph_reg)
        begin
            work_reg[ri] <= add_y;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, status_reg, granted_reg};

    `BRC_ASSERT_IMP(a_no_accept_busy, state_reg != S_IDLE, !s_axis_tready)
    `BRC_ASSERT_IMP(a_done_bound, state_reg == S_SCAN_END, done_reg <= np)
    `BRC_ASSERT_NEXT(a_result_valid, state_reg == S_RESULT, m_axis_tvalid)
endmodule

// ===== hdl/brc_ram.sv =====
// Generic single-write, single-read RAM with registered read for the request checker.
// No dependencies.
module brc_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
